// ----- hw/rtl/frml_pkg.sv -----
// ----------------------------------------------------------------------------
// frml_pkg
// Shared constants, types and state encoding of the frame rate meter/limiter.
// ----------------------------------------------------------------------------
package frml_pkg;

  localparam int WINDOW     = 5;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TIME_W     = 32;
  localparam int IVL_W      = 16;
  localparam int CFG_W      = 10;
  localparam int Q8_W       = 18;
  localparam int WAIT_W     = 10;
  localparam int SUM_W      = IVL_W + CNT_W;
  localparam int NUM_W      = Q8_W + CNT_W;

  localparam logic [IVL_W-1:0] IVL_MAX    = '1;
  localparam logic [NUM_W-1:0] RATE_SCALE = NUM_W'(256000);
  localparam logic [Q8_W-1:0]  RATE_MAX   = Q8_W'(256000);
  localparam logic [Q8_W-1:0]  RATE_IDLE  = Q8_W'(120 * 256);
  localparam logic [NUM_W-1:0] PERIOD_NUM = NUM_W'(1000);
  localparam logic [CFG_W-1:0] RATE_RESET = CFG_W'(60);

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIVP,
    S_DIVR,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/frml_ram.sv -----
// ----------------------------------------------------------------------------
// frml_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/frml_div.sv -----
// ----------------------------------------------------------------------------
// frml_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frml_div (
  input  logic                clk,
  input  logic                rst_n,
  input  frml_pkg::div_req_t  req,
  output frml_pkg::div_rsp_t  rsp
);

  localparam int STEP_W = $clog2(frml_pkg::NUM_W);

  logic                          busy_r,  busy_nxt;
  logic                          done_r,  done_nxt;
  logic [STEP_W-1:0]             step_r,  step_nxt;
  logic [frml_pkg::NUM_W-1:0]    quo_r,   quo_nxt;
  logic [frml_pkg::SUM_W-1:0]    rem_r,   rem_nxt;
  logic [frml_pkg::SUM_W-1:0]    dvs_r,   dvs_nxt;
  logic [frml_pkg::SUM_W:0]      rem_sh;
  logic [frml_pkg::SUM_W:0]      rem_sub;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, quo_r[frml_pkg::NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[frml_pkg::SUM_W-1:0];
        quo_nxt = {quo_r[frml_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[frml_pkg::SUM_W-1:0];
        quo_nxt = {quo_r[frml_pkg::NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(frml_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef NO_ASSERTIONS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= STEP_W'(frml_pkg::NUM_W - 1))
    else $error("divider step count out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r && step_r == '0)
    else $error("divider did not start");
`endif

endmodule

// ----- hw/rtl/frame_rate_meter_limiter.sv -----
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter
// Frame rate meter and limiter over a ring of the last frame intervals.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat per frame event. in_mode 0 marks
// frame begin and records in_now_ms as frame start; it gives no result.
// in_mode 1 marks frame end and gives one result beat on the out_ channel:
// averaged rate in Q.8, wait to meet the maximum rate, and the saturated
// interval since the previous frame end.
// Configuration (cfg_valid/cfg_ready): cfg_max_rate, always ready; write it
// only while no event is in flight.
// An end event raises out_valid after one ring RAM read, one read-modify-write
// of the running sum, then two runs of the shared one-bit-per-cycle divider
// (target period, then average rate; the second run is skipped when the sum
// of ring intervals is zero).
// One event is processed at a time; in_ready is low while an end event is
// in flight. The result sits in an output register; a stalled receiver
// holds it there and the next end event waits at its final step.
// Reset (synchronous, rst_n low) clears ring state and timestamps and sets
// the maximum rate to 60; the ring RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module frame_rate_meter_limiter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [frml_pkg::TIME_W-1:0]    in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [frml_pkg::Q8_W-1:0]      out_rate_q8,
  output logic [frml_pkg::WAIT_W-1:0]    out_wait_ms,
  output logic [frml_pkg::IVL_W-1:0]     out_interval_ms,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frml_pkg::CFG_W-1:0]     cfg_max_rate
);

  frml_pkg::state_t                state_r, state_nxt;
  logic [frml_pkg::CFG_W-1:0]      max_rate_r;
  logic [frml_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [frml_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [frml_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic                            seen_r, seen_nxt;
  logic [frml_pkg::TIME_W-1:0]     last_end_r, last_end_nxt;
  logic [frml_pkg::TIME_W-1:0]     start_r, start_nxt;
  logic [frml_pkg::TIME_W-1:0]     now_r, now_nxt;
  logic [frml_pkg::IVL_W-1:0]      ivl_r, ivl_nxt;
  logic [frml_pkg::WAIT_W-1:0]     period_r, period_nxt;
  logic [frml_pkg::Q8_W-1:0]       rate_r, rate_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [frml_pkg::Q8_W-1:0]       out_rate_r, out_rate_nxt;
  logic [frml_pkg::WAIT_W-1:0]     out_wait_r, out_wait_nxt;
  logic [frml_pkg::IVL_W-1:0]      out_ivl_r, out_ivl_nxt;

  logic                            ram_re, ram_we;
  logic [frml_pkg::IVL_W-1:0]      ram_rdata;
  frml_pkg::div_req_t              div_req;
  frml_pkg::div_rsp_t              div_rsp;

  logic [frml_pkg::TIME_W-1:0]     delta;
  logic [frml_pkg::TIME_W-1:0]     elapsed;
  logic [frml_pkg::CFG_W-1:0]      rate_fix;
  logic                            full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == frml_pkg::S_IDLE);
  assign delta     = seen_r ? in_now_ms - last_end_r : '0;
  assign elapsed   = now_r - start_r;
  assign rate_fix  = (max_rate_r == '0) ? frml_pkg::CFG_W'(1) : max_rate_r;
  assign full      = (cnt_r == frml_pkg::CNT_W'(frml_pkg::WINDOW));

  frml_ram #(
    .WIDTH(frml_pkg::IVL_W),
    .DEPTH(frml_pkg::WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r),
    .wdata(ivl_r),
    .re   (ram_re),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  frml_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    cnt_nxt          = cnt_r;
    sum_nxt          = sum_r;
    seen_nxt         = seen_r;
    last_end_nxt     = last_end_r;
    start_nxt        = start_r;
    now_nxt          = now_r;
    ivl_nxt          = ivl_r;
    period_nxt       = period_r;
    rate_nxt         = rate_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_rate_nxt     = out_rate_r;
    out_wait_nxt     = out_wait_r;
    out_ivl_nxt      = out_ivl_r;
    ram_re           = 1'b0;
    ram_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = frml_pkg::PERIOD_NUM;
    div_req.divisor  = frml_pkg::SUM_W'(rate_fix);
    unique case (state_r)
      frml_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            now_nxt      = in_now_ms;
            ivl_nxt      = (|delta[frml_pkg::TIME_W-1:frml_pkg::IVL_W]) ?
                           frml_pkg::IVL_MAX : delta[frml_pkg::IVL_W-1:0];
            last_end_nxt = in_now_ms;
            seen_nxt     = 1'b1;
            ram_re       = 1'b1;
            state_nxt    = frml_pkg::S_READ;
          end else begin
            start_nxt = in_now_ms;
          end
        end
      end
      frml_pkg::S_READ: begin
        sum_nxt = sum_r - (full ? frml_pkg::SUM_W'(ram_rdata) : '0)
                  + frml_pkg::SUM_W'(ivl_r);
        ram_we  = 1'b1;
        idx_nxt = (idx_r == frml_pkg::IDX_W'(frml_pkg::WINDOW - 1)) ?
                  '0 : idx_r + 1'b1;
        if (!full) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        div_req.start = 1'b1;
        state_nxt     = frml_pkg::S_DIVP;
      end
      frml_pkg::S_DIVP: begin
        div_req.dividend = frml_pkg::RATE_SCALE * frml_pkg::NUM_W'(cnt_r);
        div_req.divisor  = sum_r;
        if (div_rsp.done) begin
          period_nxt = div_rsp.quotient[frml_pkg::WAIT_W-1:0];
          if (sum_r != '0) begin
            div_req.start = 1'b1;
            state_nxt     = frml_pkg::S_DIVR;
          end else begin
            rate_nxt  = frml_pkg::RATE_IDLE;
            state_nxt = frml_pkg::S_DONE;
          end
        end
      end
      frml_pkg::S_DIVR: begin
        if (div_rsp.done) begin
          rate_nxt  = (div_rsp.quotient > frml_pkg::NUM_W'(frml_pkg::RATE_MAX)) ?
                      frml_pkg::RATE_MAX : div_rsp.quotient[frml_pkg::Q8_W-1:0];
          state_nxt = frml_pkg::S_DONE;
        end
      end
      frml_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rate_nxt  = rate_r;
          out_wait_nxt  = (frml_pkg::TIME_W'(period_r) > elapsed) ?
                          period_r - elapsed[frml_pkg::WAIT_W-1:0] : '0;
          out_ivl_nxt   = ivl_r;
          state_nxt     = frml_pkg::S_IDLE;
        end
      end
      default: state_nxt = frml_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frml_pkg::S_IDLE;
      max_rate_r  <= frml_pkg::RATE_RESET;
      idx_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      seen_r      <= 1'b0;
      last_end_r  <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid) begin
        max_rate_r <= cfg_max_rate;
      end
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      seen_r      <= seen_nxt;
      last_end_r  <= last_end_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r      <= now_nxt;
    ivl_r      <= ivl_nxt;
    period_r   <= period_nxt;
    rate_r     <= rate_nxt;
    out_rate_r <= out_rate_nxt;
    out_wait_r <= out_wait_nxt;
    out_ivl_r  <= out_ivl_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_rate_q8     = out_rate_r;
  assign out_wait_ms     = out_wait_r;
  assign out_interval_ms = out_ivl_r;

`ifndef NO_ASSERTIONS
  a_read_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frml_pkg::S_READ) |-> $past(in_valid && in_ready && in_mode))
    else $error("ring read without an end beat");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= frml_pkg::CNT_W'(frml_pkg::WINDOW) &&
    idx_r <= frml_pkg::IDX_W'(frml_pkg::WINDOW - 1))
    else $error("ring index or fill count out of range");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == frml_pkg::S_DONE))
    else $error("result beat without a finished event");

  a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_rate_r <= frml_pkg::RATE_MAX)
    else $error("rate above range");
`endif

endmodule
